// ===== design/price_gap_linear_fill_macros.svh =====
// assertion helpers for the price gap fill checker
`ifndef PRICE_GAP_LINEAR_FILL_MACROS_SVH
`define PRICE_GAP_LINEAR_FILL_MACROS_SVH

// same-cycle implication
`define PGLF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pglf check failed");

// next-cycle implication
`define PGLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pglf check failed");

`endif

// ===== design/pglf_pkg.sv =====
package pglf_pkg;

  localparam int SLOTS    = 43200;
  localparam int SLOT_W   = 16;
  localparam int PRICE_W  = 32;
  localparam int DEN_W    = SLOT_W + 1;
  localparam int ENTRY_W  = 2 * PRICE_W + 1;
  localparam int CNT_W    = $clog2(PRICE_W + 1);
  localparam logic [PRICE_W-1:0] DEFAULT_PRICE_RESET = PRICE_W'(12000000);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR_INIT,
    CMD_CLR,
    CMD_WRITE,
    CMD_READ,
    CMD_SCAN_INIT,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_RD_PREV,
    CMD_CAP_PREV,
    CMD_RD_NEXT,
    CMD_CAP_NEXT,
    CMD_SETUP,
    CMD_FILL_WR,
    CMD_RESUME
  } cmd_e;

  typedef struct packed {
    logic mark;
    logic in_gap;
    logic ptr_end;
    logic first_zero;
    logic last_end;
    logic interp;
    logic wr_last;
    logic div_busy;
  } status_t;

endpackage

// ===== design/pglf_ram.sv =====
module pglf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pglf_div.sv =====
module pglf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  dividend_i,
  input  logic [pglf_pkg::DEN_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [pglf_pkg::PRICE_W-1:0]  quot_o,
  output logic [pglf_pkg::DEN_W-1:0]    rem_o
);

  logic                          busy_q, busy_d;
  logic [pglf_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [pglf_pkg::PRICE_W-1:0]  quot_q, quot_d;
  logic [pglf_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [pglf_pkg::DEN_W:0]      shifted;
  logic [pglf_pkg::DEN_W:0]      diff;
  logic                          ge;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quot_q[pglf_pkg::PRICE_W-1]};
  assign ge      = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pglf_pkg::CNT_W'(pglf_pkg::PRICE_W);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[pglf_pkg::PRICE_W-2:0], ge};
      rem_d  = ge ? diff[pglf_pkg::DEN_W-1:0] : shifted[pglf_pkg::DEN_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == pglf_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/pglf_datapath.sv =====
module pglf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pglf_pkg::cmd_e                cmd_i,
  input  logic                          rd_accept_i,
  input  logic [pglf_pkg::SLOT_W-1:0]   slot_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  ask_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  bid_i,
  input  logic                          cfg_we_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  cfg_wdata_i,
  output pglf_pkg::status_t             status_o,
  output logic [pglf_pkg::PRICE_W-1:0]  ask_out_o,
  output logic [pglf_pkg::PRICE_W-1:0]  bid_out_o,
  output logic                          missing_o
);

  localparam int P = pglf_pkg::PRICE_W;
  localparam int W = pglf_pkg::SLOT_W;
  localparam int D = pglf_pkg::DEN_W;
  localparam logic [W-1:0] LAST_SLOT = W'(pglf_pkg::SLOTS - 1);

  logic [P-1:0] default_q;
  logic [W-1:0] ptr_q, first_q, last_q;
  logic         in_gap_q, interp_q, up_a_q, up_b_q;
  logic [P-1:0] prev_a_q, prev_b_q, next_a_q, next_b_q;
  logic [P-1:0] q_a_q, q_b_q;
  logic [D-1:0] r_a_q, r_b_q, den_q;
  logic         rd_sel_q, rd_oor_q;

  logic                      we;
  logic [W-1:0]              waddr, raddr;
  logic [pglf_pkg::ENTRY_W-1:0] wdata, rdata;
  logic                      mark, slot_ok, div_start;
  logic [P-1:0]              dvd_a, dvd_b, quo_a, quo_b, step_qa, step_qb;
  logic [D-1:0]              rem_a, rem_b, step_ra, step_rb;
  logic                      busy_a, busy_b;
  logic [D:0]                t_a, t_b;
  logic                      c_a, c_b;
  logic [D-1:0]              rn_a, rn_b;
  logic [P-1:0]              qn_a, qn_b, val_a, val_b;

  assign slot_ok = 32'(slot_i) < pglf_pkg::SLOTS;
  assign mark    = rdata[pglf_pkg::ENTRY_W-1];

  pglf_ram #(
    .WIDTH(pglf_pkg::ENTRY_W),
    .DEPTH(pglf_pkg::SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // direction taken from the captured neighbors, the divider loads on setup
  assign dvd_a     = (next_a_q >= prev_a_q) ? next_a_q - prev_a_q : prev_a_q - next_a_q;
  assign dvd_b     = (next_b_q >= prev_b_q) ? next_b_q - prev_b_q : prev_b_q - next_b_q;
  assign div_start = (cmd_i == pglf_pkg::CMD_SETUP);

  pglf_div u_div_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(dvd_a), .divisor_i(den_q),
    .busy_o(busy_a), .quot_o(quo_a), .rem_o(rem_a)
  );

  pglf_div u_div_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(dvd_b), .divisor_i(den_q),
    .busy_o(busy_b), .quot_o(quo_b), .rem_o(rem_b)
  );

  // per-slot step of diff/den split as quotient and remainder; zero for plain copies
  assign step_qa = interp_q ? quo_a : '0;
  assign step_qb = interp_q ? quo_b : '0;
  assign step_ra = interp_q ? rem_a : '0;
  assign step_rb = interp_q ? rem_b : '0;

  assign t_a  = {1'b0, r_a_q} + {1'b0, step_ra};
  assign t_b  = {1'b0, r_b_q} + {1'b0, step_rb};
  assign c_a  = t_a >= {1'b0, den_q};
  assign c_b  = t_b >= {1'b0, den_q};
  assign rn_a = c_a ? D'(t_a - {1'b0, den_q}) : t_a[D-1:0];
  assign rn_b = c_b ? D'(t_b - {1'b0, den_q}) : t_b[D-1:0];
  assign qn_a = q_a_q + step_qa + P'(c_a);
  assign qn_b = q_b_q + step_qb + P'(c_b);
  assign val_a = up_a_q ? prev_a_q + qn_a : prev_a_q - qn_a;
  assign val_b = up_b_q ? prev_b_q + qn_b : prev_b_q - qn_b;

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = {1'b1, val_a, val_b};
    raddr = ptr_q;
    case (cmd_i)
      pglf_pkg::CMD_CLR: begin
        we    = 1'b1;
        wdata = {1'b1, default_q, default_q};
      end
      pglf_pkg::CMD_WRITE: begin
        we    = slot_ok;
        waddr = slot_i;
        wdata = {1'b0, ask_i, bid_i};
      end
      pglf_pkg::CMD_FILL_WR: we = 1'b1;
      pglf_pkg::CMD_READ:    raddr = slot_i;
      pglf_pkg::CMD_RD_PREV: raddr = first_q - 1'b1;
      pglf_pkg::CMD_RD_NEXT: raddr = last_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= pglf_pkg::DEFAULT_PRICE_RESET;
      in_gap_q  <= 1'b0;
      rd_sel_q  <= 1'b0;
      rd_oor_q  <= 1'b0;
      ptr_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        default_q <= cfg_wdata_i;
      end
      rd_sel_q <= rd_accept_i && slot_ok;
      rd_oor_q <= rd_accept_i && !slot_ok;
      case (cmd_i)
        pglf_pkg::CMD_CLR_INIT: ptr_q <= '0;
        pglf_pkg::CMD_CLR:      ptr_q <= ptr_q + 1'b1;
        pglf_pkg::CMD_SCAN_INIT: begin
          ptr_q    <= '0;
          in_gap_q <= 1'b0;
        end
        pglf_pkg::CMD_SCAN_CHK: begin
          if (in_gap_q && !mark) begin
            in_gap_q <= 1'b0;
          end else begin
            if (!in_gap_q && mark) begin
              in_gap_q <= 1'b1;
            end
            if (ptr_q == LAST_SLOT) begin
              in_gap_q <= 1'b0;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
        end
        pglf_pkg::CMD_SETUP:   ptr_q <= first_q;
        pglf_pkg::CMD_FILL_WR: ptr_q <= ptr_q + 1'b1;
        pglf_pkg::CMD_RESUME:  ptr_q <= last_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      pglf_pkg::CMD_SCAN_CHK: begin
        if (in_gap_q && !mark) begin
          last_q <= ptr_q - 1'b1;
        end else begin
          if (!in_gap_q && mark) begin
            first_q <= ptr_q;
          end
          if (ptr_q == LAST_SLOT) begin
            last_q <= ptr_q;
          end
        end
      end
      pglf_pkg::CMD_CAP_PREV: begin
        prev_a_q <= rdata[2*P-1:P];
        prev_b_q <= rdata[P-1:0];
      end
      pglf_pkg::CMD_CAP_NEXT: begin
        next_a_q <= rdata[2*P-1:P];
        next_b_q <= rdata[P-1:0];
      end
      pglf_pkg::CMD_SETUP: begin
        // leading gap copies the next valid slot
        if (first_q == '0) begin
          prev_a_q <= next_a_q;
          prev_b_q <= next_b_q;
        end
        interp_q <= (first_q != '0) && (last_q != LAST_SLOT);
        up_a_q   <= next_a_q >= prev_a_q;
        up_b_q   <= next_b_q >= prev_b_q;
        den_q    <= D'(last_q) - D'(first_q) + D'(2);
        q_a_q    <= '0;
        q_b_q    <= '0;
        r_a_q    <= '0;
        r_b_q    <= '0;
      end
      pglf_pkg::CMD_FILL_WR: begin
        q_a_q <= qn_a;
        q_b_q <= qn_b;
        r_a_q <= rn_a;
        r_b_q <= rn_b;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o            = '0;
    status_o.mark       = mark;
    status_o.in_gap     = in_gap_q;
    status_o.ptr_end    = ptr_q == LAST_SLOT;
    status_o.first_zero = first_q == '0;
    status_o.last_end   = last_q == LAST_SLOT;
    status_o.interp     = interp_q;
    status_o.wr_last    = ptr_q == last_q;
    status_o.div_busy   = busy_a || busy_b;
  end

  assign ask_out_o = rd_sel_q ? rdata[2*P-1:P] : '0;
  assign bid_out_o = rd_sel_q ? rdata[P-1:0] : '0;
  assign missing_o = rd_sel_q ? mark : rd_oor_q;

endmodule

// ===== design/pglf_ctrl.sv =====
module pglf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  pglf_pkg::status_t  status_i,
  output pglf_pkg::cmd_e     cmd_o,
  output logic               rd_accept_o,
  output logic               busy_o,
  output logic               done_o
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_CLR  = 13'b0000000000010,
    ST_SCAN = 13'b0000000000100,
    ST_SCHK = 13'b0000000001000,
    ST_RP   = 13'b0000000010000,
    ST_CP   = 13'b0000000100000,
    ST_RN   = 13'b0000001000000,
    ST_CN   = 13'b0000010000000,
    ST_SET  = 13'b0000100000000,
    ST_DIV  = 13'b0001000000000,
    ST_WR   = 13'b0010000000000,
    ST_GEND = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   gap_found;

  assign gap_found = (status_i.in_gap && !status_i.mark) ||
                     (status_i.ptr_end && (status_i.in_gap || status_i.mark));

  always_comb begin
    state_d     = state_q;
    cmd_o       = pglf_pkg::CMD_NONE;
    done_d      = 1'b0;
    rd_accept_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (pglf_pkg::mode_e'(mode_i))
            pglf_pkg::MODE_CLEAR: begin
              cmd_o   = pglf_pkg::CMD_CLR_INIT;
              state_d = ST_CLR;
            end
            pglf_pkg::MODE_WRITE: begin
              cmd_o  = pglf_pkg::CMD_WRITE;
              done_d = 1'b1;
            end
            pglf_pkg::MODE_FILL: begin
              cmd_o   = pglf_pkg::CMD_SCAN_INIT;
              state_d = ST_SCAN;
            end
            default: begin
              cmd_o       = pglf_pkg::CMD_READ;
              rd_accept_o = 1'b1;
              done_d      = 1'b1;
            end
          endcase
        end
      end
      ST_CLR: begin
        cmd_o = pglf_pkg::CMD_CLR;
        if (status_i.ptr_end) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o   = pglf_pkg::CMD_SCAN_RD;
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        cmd_o = pglf_pkg::CMD_SCAN_CHK;
        if (gap_found) begin
          state_d = ST_RP;
        end else if (status_i.ptr_end) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_RP: begin
        if (status_i.first_zero) begin
          state_d = ST_RN;
        end else begin
          cmd_o   = pglf_pkg::CMD_RD_PREV;
          state_d = ST_CP;
        end
      end
      ST_CP: begin
        cmd_o   = pglf_pkg::CMD_CAP_PREV;
        state_d = ST_RN;
      end
      ST_RN: begin
        if (status_i.last_end) begin
          state_d = ST_SET;
        end else begin
          cmd_o   = pglf_pkg::CMD_RD_NEXT;
          state_d = ST_CN;
        end
      end
      ST_CN: begin
        cmd_o   = pglf_pkg::CMD_CAP_NEXT;
        state_d = ST_SET;
      end
      ST_SET: begin
        // whole day missing keeps the defaults
        if (status_i.first_zero && status_i.last_end) begin
          state_d = ST_GEND;
        end else begin
          cmd_o   = pglf_pkg::CMD_SETUP;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.interp || !status_i.div_busy) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        cmd_o = pglf_pkg::CMD_FILL_WR;
        if (status_i.wr_last) begin
          state_d = ST_GEND;
        end
      end
      ST_GEND: begin
        cmd_o = pglf_pkg::CMD_RESUME;
        if (status_i.last_end) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;

endmodule

// ===== design/price_gap_linear_fill.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------
// command   | start, busy           | mode_i, slot_i, ask_i, bid_i
// result    | done_o (1-cycle pulse)| ask_out_o, bid_out_o, missing_o
// config    | cfg_we_i              | cfg_wdata_i (default price)
//
// write and read items are taken every cycle while idle; result the cycle after accept.
// clear sweeps the slot memory one entry a cycle, then gives the result.
// fill scans the day slot by slot through the memory read port, a read then a check;
// each gap reads neighbours, waits for an interior divide, writes each slot, rescans.
// async active-low reset leaves the slot memory undefined until a clear.
// the receiver cannot stall; the result is on the ports for one cycle only.
module price_gap_linear_fill (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [pglf_pkg::SLOT_W-1:0]   slot_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  ask_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  bid_i,
  input  logic                          cfg_we_i,
  input  logic [pglf_pkg::PRICE_W-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic [pglf_pkg::PRICE_W-1:0]  ask_out_o,
  output logic [pglf_pkg::PRICE_W-1:0]  bid_out_o,
  output logic                          missing_o
);

  pglf_pkg::cmd_e    cmd;
  pglf_pkg::status_t status;
  logic              rd_accept;

  pglf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .mode_i     (mode_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_accept_o(rd_accept),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  pglf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_accept_i(rd_accept),
    .slot_i     (slot_i),
    .ask_i      (ask_i),
    .bid_i      (bid_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .status_o   (status),
    .ask_out_o  (ask_out_o),
    .bid_out_o  (bid_out_o),
    .missing_o  (missing_o)
  );

endmodule

// ===== design/pglf_checker.sv =====
`include "price_gap_linear_fill_macros.svh"

module pglf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    mode_i,
  input logic                          done_o,
  input logic [pglf_pkg::PRICE_W-1:0]  ask_out_o,
  input logic [pglf_pkg::PRICE_W-1:0]  bid_out_o,
  input logic                          missing_o
);

  // result fields stay zero outside a result cycle
  `PGLF_ASSERT_NOW(a_quiet_out, !done_o, ask_out_o == '0 && bid_out_o == '0 && !missing_o)
  // write and read items answer in the next cycle
  `PGLF_ASSERT_NXT(a_fast_done, start && !busy && (mode_i == pglf_pkg::MODE_WRITE || mode_i == pglf_pkg::MODE_READ), done_o)
  // clear and fill occupy the block
  `PGLF_ASSERT_NXT(a_long_busy, start && !busy && (mode_i == pglf_pkg::MODE_CLEAR || mode_i == pglf_pkg::MODE_FILL), busy)
  // a result never appears while an item is still in work
  `PGLF_ASSERT_NOW(a_done_idle, done_o, !busy)

endmodule

bind price_gap_linear_fill pglf_checker u_pglf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .mode_i   (mode_i),
  .done_o   (done_o),
  .ask_out_o(ask_out_o),
  .bid_out_o(bid_out_o),
  .missing_o(missing_o)
);

// ===== tb/price_gap_linear_fill_test.sv =====
module price_gap_linear_fill_test;
  import pglf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000000;
  localparam int MAX_GAP        = 18;

  typedef struct {
    logic [PRICE_W-1:0] ask;
    logic [PRICE_W-1:0] bid;
    logic               miss;
  } slot_reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = MODE_READ;
  logic [SLOT_W-1:0]  slot_i = '0;
  logic [PRICE_W-1:0] ask_i = '0;
  logic [PRICE_W-1:0] bid_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [PRICE_W-1:0] cfg_wdata_i = '0;
  logic               done_o;
  logic [PRICE_W-1:0] ask_out_o;
  logic [PRICE_W-1:0] bid_out_o;
  logic               missing_o;

  // shadow copy of the day
  logic [PRICE_W-1:0] day_ask [SLOTS];
  logic [PRICE_W-1:0] day_bid [SLOTS];
  bit                 day_miss [SLOTS];
  logic [SLOT_W-1:0]  last_gap_start;
  logic [PRICE_W-1:0] clear_price;

  slot_reading_t pending_readings[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  price_gap_linear_fill uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .slot_i      (slot_i),
    .ask_i       (ask_i),
    .bid_i       (bid_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .ask_out_o   (ask_out_o),
    .bid_out_o   (bid_out_o),
    .missing_o   (missing_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [PRICE_W-1:0] lerp_price(logic [63:0] lo, logic [63:0] hi,
                                                    logic [63:0] k, logic [63:0] den);
    if (hi >= lo) return PRICE_W'(lo + ((hi - lo) * k) / den);
    return PRICE_W'(lo - ((lo - hi) * k) / den);
  endfunction

  function automatic void fill_run(int first, int last);
    logic [63:0] den;
    logic [63:0] pa, na, pb, nb;
    last_gap_start = SLOT_W'(first);
    if (first == 0) begin
      if (last == SLOTS - 1) return;  // empty day keeps defaults
      for (int s = 0; s <= last; s++) begin
        day_ask[s] = day_ask[last + 1];
        day_bid[s] = day_bid[last + 1];
      end
    end else if (last == SLOTS - 1) begin
      for (int s = first; s < SLOTS; s++) begin
        day_ask[s] = day_ask[first - 1];
        day_bid[s] = day_bid[first - 1];
      end
    end else begin
      den = 64'(last - first) + 64'd2;
      pa = day_ask[first - 1];
      na = day_ask[last + 1];
      pb = day_bid[first - 1];
      nb = day_bid[last + 1];
      for (int s = first; s <= last; s++) begin
        day_ask[s] = lerp_price(pa, na, 64'(s - first + 1), den);
        day_bid[s] = lerp_price(pb, nb, 64'(s - first + 1), den);
      end
    end
  endfunction

  function automatic slot_reading_t predict_item(mode_e m, logic [SLOT_W-1:0] s,
                                                 logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    slot_reading_t r;
    int e;
    int p;
    r = '{ask: '0, bid: '0, miss: 1'b0};
    case (m)
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          day_ask[i] = clear_price;
          day_bid[i] = clear_price;
          day_miss[i] = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (s < SLOTS) begin
          day_ask[s] = a;
          day_bid[s] = b;
          day_miss[s] = 1'b0;
        end
      end
      MODE_FILL: begin
        p = 0;
        while (p < SLOTS) begin
          if (!day_miss[p]) begin
            p++;
          end else begin
            e = p;
            while (e + 1 < SLOTS && day_miss[e + 1]) e++;
            fill_run(p, e);
            p = e + 1;
          end
        end
      end
      default: begin
        if (s < SLOTS) r = '{ask: day_ask[s], bid: day_bid[s], miss: day_miss[s]};
        else r.miss = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic send_item(mode_e m, logic [SLOT_W-1:0] s,
                           logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    mode_i <= m;
    slot_i <= s;
    ask_i  <= a;
    bid_i  <= b;
    do @(posedge clk_i); while (busy);
    pending_readings.push_back(predict_item(m, s, a, b));
  endtask

  task automatic set_default_price(logic [PRICE_W-1:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    clear_price = v;
  endtask

  always @(posedge clk_i) begin
    slot_reading_t want;
    if (rst_ni && done_o) begin
      if (pending_readings.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (ask_out_o !== want.ask) begin
          $error("ask_out expected %0d got %0d", want.ask, ask_out_o);
          fail_count++;
        end
        if (bid_out_o !== want.bid) begin
          $error("bid_out expected %0d got %0d", want.bid, bid_out_o);
          fail_count++;
        end
        if (missing_o !== want.miss) begin
          $error("missing expected %0d got %0d", want.miss, missing_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reset default price, leading, interior, trailing gaps and out-of-range slots
  task automatic test_gap_shapes();
    send_item(MODE_CLEAR, '0, '0, '0);
    send_item(MODE_READ, 16'd100, '0, '0);
    send_item(MODE_WRITE, 16'd3, 32'd1000, 32'hFFFF_FFFF);
    send_item(MODE_WRITE, 16'd7, 32'hFFFF_FFFF, 32'd0);
    send_item(MODE_WRITE, 16'd43198, 32'd0, 32'd5);
    send_item(MODE_WRITE, 16'hFFFF, 32'd77, 32'd77);
    send_item(MODE_WRITE, 16'd43200, 32'd88, 32'd88);
    send_item(MODE_FILL, '0, '0, '0);
    send_item(MODE_READ, 16'd0, '0, '0);
    send_item(MODE_READ, 16'd2, '0, '0);
    send_item(MODE_READ, 16'd3, '0, '0);
    send_item(MODE_READ, 16'd5, '0, '0);
    send_item(MODE_READ, 16'd6, '0, '0);
    send_item(MODE_READ, 16'd100, '0, '0);
    send_item(MODE_READ, 16'd43199, '0, '0);
    send_item(MODE_READ, 16'hFFFF, '0, '0);
    send_item(MODE_READ, 16'd43200, '0, '0);
  endtask

  // a day without samples keeps the default everywhere
  task automatic test_empty_day();
    set_default_price(32'hFFFF_FFFF);
    send_item(MODE_CLEAR, '0, '0, '0);
    send_item(MODE_FILL, '0, '0, '0);
    send_item(MODE_READ, 16'd0, '0, '0);
    send_item(MODE_READ, 16'd21600, '0, '0);
    send_item(MODE_READ, 16'd43199, '0, '0);
  endtask

  // samples clustered around a few spots, one fill part way through
  task automatic test_random_day(logic [PRICE_W-1:0] dflt, int n_items);
    int centers[4];
    int s;
    int pick;
    set_default_price(dflt);
    for (int i = 0; i < 4; i++) centers[i] = $urandom_range(0, SLOTS - 1);
    centers[0] = $urandom_range(0, 40);
    centers[1] = $urandom_range(SLOTS - 60, SLOTS - 1);
    send_item(MODE_CLEAR, '0, '0, '0);
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
        s = $urandom_range(0, 65535);
      end else begin
        s = centers[$urandom_range(0, 3)] + $urandom_range(0, 60);
        if (s >= SLOTS) s = SLOTS - 1;
      end
      if (n == n_items * 3 / 5) begin
        send_item(MODE_FILL, SLOT_W'($urandom), $urandom, $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          send_item(MODE_WRITE, SLOT_W'(s), $urandom, $urandom);
        else
          send_item(MODE_READ, SLOT_W'(s), $urandom, $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_price = DEFAULT_PRICE_RESET;
    last_gap_start = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_gap_shapes();
    test_empty_day();
    test_random_day(32'd0, 175);
    test_random_day($urandom, 175);
    test_random_day(32'hFFFF_FFFF, 175);

    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
